// ===== hw/rtl/eic_pkg.sv =====
package eic_pkg;

  // Field and register widths
  localparam int ENTRY_W    = 16;
  localparam int FRAC_BITS  = 16;
  localparam int ROW_W      = 3 * ENTRY_W;
  localparam int THR_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = ROW_W;

  // Parameter defaults
  localparam int COUNT_BITS_DEF = 16;
  localparam int COORD_BITS_DEF = 20;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROW_ZERO  = 2'd0,
    CFG_ROW_ONE   = 2'd1,
    CFG_ROW_TWO   = 2'd2,
    CFG_THRESHOLD = 2'd3
  } cfg_idx_e;

  // Signed width of one entry of E*x2 or E^T*x1
  function automatic int vec_w(input int cb);
    return cb + ENTRY_W + 1;
  endfunction

  // Signed width of the epipolar residual
  function automatic int res_w(input int cb);
    return 2 * cb + ENTRY_W + 2;
  endfunction

  // Width of the residual magnitude
  function automatic int res_mag_w(input int cb);
    return 2 * cb + ENTRY_W + 1;
  endfunction

  // Unsigned width of the Sampson denominator
  function automatic int den_w(input int cb);
    return 2 * (cb + ENTRY_W) + 2;
  endfunction

  // One signed Q2.14 entry out of a packed matrix row, column 0 in the low bits
  function automatic logic signed [ENTRY_W-1:0] mat_entry(input logic [ROW_W-1:0] row,
                                                          input int unsigned col);
    return row[col*ENTRY_W +: ENTRY_W];
  endfunction

endpackage

// ===== hw/rtl/epipolar_inlier_counter_top.sv =====
// Channel   Direction  Handshake                 Word
// in        input      in_valid_i / in_ready_o   first_x, first_y, second_x, second_y, final_pair
// out       output     out_valid_o / out_ready_i is_inlier, inlier_total, set_done
// cfg       input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i (always ready)
//
// One correspondence enters per cycle while in_ready_o is high; each word passes
// the matrix-vector, residual/denominator, wide multiply and compare, and count
// stages on its way from input to output register.
// Reset clears the matrix, threshold, support count and all stage valid bits.
// Each stage holds its word while the next is full, so stalls drop nothing.
module epipolar_inlier_counter_top #(
  parameter int COUNT_BITS = eic_pkg::COUNT_BITS_DEF,
  parameter int COORD_BITS = eic_pkg::COORD_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic signed [COORD_BITS-1:0]      first_x_i,
  input  logic signed [COORD_BITS-1:0]      first_y_i,
  input  logic signed [COORD_BITS-1:0]      second_x_i,
  input  logic signed [COORD_BITS-1:0]      second_y_i,
  input  logic                              final_pair_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              is_inlier_o,
  output logic [COUNT_BITS-1:0]             inlier_total_o,
  output logic                              set_done_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [eic_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [eic_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int AW  = eic_pkg::vec_w(COORD_BITS);
  localparam int RMW = eic_pkg::res_mag_w(COORD_BITS);
  localparam int DW  = eic_pkg::den_w(COORD_BITS);

  // Configuration registers
  logic [eic_pkg::ROW_W-1:0] rows_q [3];
  logic [eic_pkg::THR_W-1:0] thr_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q[0] <= '0;
      rows_q[1] <= '0;
      rows_q[2] <= '0;
      thr_q     <= '0;
    end else if (cfg_valid_i) begin
      unique case (eic_pkg::cfg_idx_e'(cfg_index_i))
        eic_pkg::CFG_ROW_ZERO:  rows_q[0] <= cfg_data_i;
        eic_pkg::CFG_ROW_ONE:   rows_q[1] <= cfg_data_i;
        eic_pkg::CFG_ROW_TWO:   rows_q[2] <= cfg_data_i;
        eic_pkg::CFG_THRESHOLD: thr_q     <= cfg_data_i[eic_pkg::THR_W-1:0];
      endcase
    end
  end

  // Matrix-vector products
  logic                         mv_valid, mv_ready, mv_last;
  logic signed [AW-1:0]         mv_a [3];
  logic signed [AW-1:0]         mv_b [2];
  logic signed [COORD_BITS-1:0] mv_x1x, mv_x1y;

  eic_matvec #(
    .COORD_BITS(COORD_BITS)
  ) u_matvec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .x1x_i       (first_x_i),
    .x1y_i       (first_y_i),
    .x2x_i       (second_x_i),
    .x2y_i       (second_y_i),
    .last_i      (final_pair_i),
    .rows_i      (rows_q),
    .out_valid_o (mv_valid),
    .out_ready_i (mv_ready),
    .a_o         (mv_a),
    .b_o         (mv_b),
    .x1x_o       (mv_x1x),
    .x1y_o       (mv_x1y),
    .last_o      (mv_last)
  );

  // Residual and denominator
  logic           qd_valid, qd_ready, qd_last;
  logic [RMW-1:0] qd_rmag;
  logic [DW-1:0]  qd_den;

  eic_quad #(
    .COORD_BITS(COORD_BITS)
  ) u_quad (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mv_valid),
    .in_ready_o  (mv_ready),
    .a_i         (mv_a),
    .b_i         (mv_b),
    .x1x_i       (mv_x1x),
    .x1y_i       (mv_x1y),
    .last_i      (mv_last),
    .out_valid_o (qd_valid),
    .out_ready_i (qd_ready),
    .rmag_o      (qd_rmag),
    .den_o       (qd_den),
    .last_o      (qd_last)
  );

  // Threshold test
  logic cp_valid, cp_ready, cp_inl, cp_last;

  eic_cmp #(
    .COORD_BITS(COORD_BITS)
  ) u_cmp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (qd_valid),
    .in_ready_o  (qd_ready),
    .rmag_i      (qd_rmag),
    .den_i       (qd_den),
    .thr_i       (thr_q),
    .last_i      (qd_last),
    .out_valid_o (cp_valid),
    .out_ready_i (cp_ready),
    .inl_o       (cp_inl),
    .last_o      (cp_last)
  );

  // Support count and output register
  eic_count #(
    .COUNT_BITS(COUNT_BITS)
  ) u_count (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cp_valid),
    .in_ready_o  (cp_ready),
    .inl_i       (cp_inl),
    .last_i      (cp_last),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .is_inlier_o (is_inlier_o),
    .total_o     (inlier_total_o),
    .done_o      (set_done_o)
  );

endmodule

// ===== hw/rtl/eic_matvec.sv =====
module eic_matvec #(
  parameter int COORD_BITS = eic_pkg::COORD_BITS_DEF
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         in_valid_i,
  output logic                                         in_ready_o,
  input  logic signed [COORD_BITS-1:0]                 x1x_i,
  input  logic signed [COORD_BITS-1:0]                 x1y_i,
  input  logic signed [COORD_BITS-1:0]                 x2x_i,
  input  logic signed [COORD_BITS-1:0]                 x2y_i,
  input  logic                                         last_i,
  input  logic [eic_pkg::ROW_W-1:0]                    rows_i [3],
  output logic                                         out_valid_o,
  input  logic                                         out_ready_i,
  output logic signed [eic_pkg::vec_w(COORD_BITS)-1:0] a_o [3],
  output logic signed [eic_pkg::vec_w(COORD_BITS)-1:0] b_o [2],
  output logic signed [COORD_BITS-1:0]                 x1x_o,
  output logic signed [COORD_BITS-1:0]                 x1y_o,
  output logic                                         last_o
);

  localparam int PW = COORD_BITS + eic_pkg::ENTRY_W;
  localparam int AW = eic_pkg::vec_w(COORD_BITS);
  localparam int NS = 2;

  // Constant-column term: entry times homogeneous 1.0
  function automatic logic signed [AW-1:0] lift(input logic signed [eic_pkg::ENTRY_W-1:0] e);
    return AW'(e) <<< eic_pkg::FRAC_BITS;
  endfunction

  logic [NS-1:0] v_q;
  logic [NS-1:0] en;

  // Stage enables: a stage loads when empty or when its word moves on
  always_comb begin
    en[NS-1] = !v_q[NS-1] || out_ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      if (en[1]) v_q[1] <= v_q[0];
    end
  end

  // Stage 1: entry-by-coordinate products
  logic signed [PW-1:0]         pa_q [3][2];
  logic signed [PW-1:0]         pb_q [2][2];
  logic signed [COORD_BITS-1:0] x1x_q, x1y_q;
  logic                         last_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int i = 0; i < 3; i++) begin
        pa_q[i][0] <= eic_pkg::mat_entry(rows_i[i], 0) * x2x_i;
        pa_q[i][1] <= eic_pkg::mat_entry(rows_i[i], 1) * x2y_i;
      end
      for (int i = 0; i < 2; i++) begin
        pb_q[i][0] <= eic_pkg::mat_entry(rows_i[0], i) * x1x_i;
        pb_q[i][1] <= eic_pkg::mat_entry(rows_i[1], i) * x1y_i;
      end
      x1x_q  <= x1x_i;
      x1y_q  <= x1y_i;
      last_q <= last_i;
    end
  end

  // Stage 2: sums for a = E*x2 and the first two entries of b = E^T*x1
  logic signed [AW-1:0] a_d [3];
  logic signed [AW-1:0] b_d [2];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      a_d[i] = AW'(pa_q[i][0]) + AW'(pa_q[i][1])
             + lift(eic_pkg::mat_entry(rows_i[i], 2));
    end
    for (int i = 0; i < 2; i++) begin
      b_d[i] = AW'(pb_q[i][0]) + AW'(pb_q[i][1])
             + lift(eic_pkg::mat_entry(rows_i[2], i));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      a_o    <= a_d;
      b_o    <= b_d;
      x1x_o  <= x1x_q;
      x1y_o  <= x1y_q;
      last_o <= last_q;
    end
  end

  assign out_valid_o = v_q[NS-1];

endmodule

// ===== hw/rtl/eic_quad.sv =====
module eic_quad #(
  parameter int COORD_BITS = eic_pkg::COORD_BITS_DEF
) (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  logic                                             in_valid_i,
  output logic                                             in_ready_o,
  input  logic signed [eic_pkg::vec_w(COORD_BITS)-1:0]     a_i [3],
  input  logic signed [eic_pkg::vec_w(COORD_BITS)-1:0]     b_i [2],
  input  logic signed [COORD_BITS-1:0]                     x1x_i,
  input  logic signed [COORD_BITS-1:0]                     x1y_i,
  input  logic                                             last_i,
  output logic                                             out_valid_o,
  input  logic                                             out_ready_i,
  output logic [eic_pkg::res_mag_w(COORD_BITS)-1:0]        rmag_o,
  output logic [eic_pkg::den_w(COORD_BITS)-1:0]            den_o,
  output logic                                             last_o
);

  localparam int CW  = COORD_BITS;
  localparam int AW  = eic_pkg::vec_w(COORD_BITS);
  localparam int MW  = AW - 1;
  localparam int LW  = (MW + 1) / 2;
  localparam int HW  = MW - LW;
  localparam int PHW = CW + AW - LW;
  localparam int PLW = CW + LW + 1;
  localparam int TW  = CW + AW;
  localparam int RW  = eic_pkg::res_w(COORD_BITS);
  localparam int RMW = eic_pkg::res_mag_w(COORD_BITS);
  localparam int SW  = 2 * MW;
  localparam int DW  = eic_pkg::den_w(COORD_BITS);
  localparam int NS  = 4;

  logic [NS-1:0] v_q;
  logic [NS-1:0] en;
  logic [NS-1:0] last_q;

  always_comb begin
    en[NS-1] = !v_q[NS-1] || out_ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // Flag for the end of a set rides along
  always_ff @(posedge clk_i) begin
    if (en[0]) last_q[0] <= last_i;
    for (int k = 1; k < NS; k++) begin
      if (en[k]) last_q[k] <= last_q[k-1];
    end
  end

  // Stage 3: magnitudes for the denominator, split residual products
  logic signed [AW-1:0] sv [4];
  logic signed [CW-1:0] xv [2];

  assign sv[0] = a_i[0];
  assign sv[1] = a_i[1];
  assign sv[2] = b_i[0];
  assign sv[3] = b_i[1];
  assign xv[0] = x1x_i;
  assign xv[1] = x1y_i;

  logic [MW-1:0]         m_q  [4];
  logic signed [PHW-1:0] ph_q [2];
  logic signed [PLW-1:0] pl_q [2];
  logic signed [AW-1:0]  a2_q;

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      for (int k = 0; k < 4; k++) begin
        m_q[k] <= sv[k][AW-1] ? MW'(-sv[k]) : MW'(sv[k]);
      end
      for (int k = 0; k < 2; k++) begin
        ph_q[k] <= xv[k] * signed'(a_i[k][AW-1:LW]);
        pl_q[k] <= xv[k] * signed'({1'b0, a_i[k][LW-1:0]});
      end
      a2_q <= a_i[2];
    end
  end

  // Stage 4: recombine residual terms, partial products of the squares
  logic signed [TW-1:0] t_q  [2];
  logic [2*HW-1:0]      hh_q [4];
  logic [HW+LW-1:0]     hl_q [4];
  logic [2*LW-1:0]      ll_q [4];
  logic signed [AW-1:0] a2_q2;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      for (int k = 0; k < 2; k++) begin
        t_q[k] <= (TW'(ph_q[k]) <<< LW) + TW'(pl_q[k]);
      end
      for (int k = 0; k < 4; k++) begin
        hh_q[k] <= m_q[k][MW-1:LW] * m_q[k][MW-1:LW];
        hl_q[k] <= m_q[k][MW-1:LW] * m_q[k][LW-1:0];
        ll_q[k] <= m_q[k][LW-1:0] * m_q[k][LW-1:0];
      end
      a2_q2 <= a2_q;
    end
  end

  // Stage 5: residual x1^T*E*x2 and each square
  logic signed [RW-1:0] r_q;
  logic [SW-1:0]        sq_q [4];

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      r_q <= RW'(t_q[0]) + RW'(t_q[1]) + (RW'(a2_q2) <<< eic_pkg::FRAC_BITS);
      for (int k = 0; k < 4; k++) begin
        sq_q[k] <= (SW'(hh_q[k]) << (2 * LW)) + (SW'(hl_q[k]) << (LW + 1)) + SW'(ll_q[k]);
      end
    end
  end

  // Stage 6: residual magnitude and denominator sum
  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      rmag_o <= r_q[RW-1] ? RMW'(-r_q) : RMW'(r_q);
      den_o  <= DW'(sq_q[0]) + DW'(sq_q[1]) + DW'(sq_q[2]) + DW'(sq_q[3]);
    end
  end

  assign out_valid_o = v_q[NS-1];
  assign last_o      = last_q[NS-1];

endmodule

// ===== hw/rtl/eic_cmp.sv =====
module eic_cmp #(
  parameter int COORD_BITS = eic_pkg::COORD_BITS_DEF
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      in_valid_i,
  output logic                                      in_ready_o,
  input  logic [eic_pkg::res_mag_w(COORD_BITS)-1:0] rmag_i,
  input  logic [eic_pkg::den_w(COORD_BITS)-1:0]     den_i,
  input  logic [eic_pkg::THR_W-1:0]                 thr_i,
  input  logic                                      last_i,
  output logic                                      out_valid_o,
  input  logic                                      out_ready_i,
  output logic                                      inl_o,
  output logic                                      last_o
);

  localparam int RMW = eic_pkg::res_mag_w(COORD_BITS);
  localparam int DW  = eic_pkg::den_w(COORD_BITS);
  localparam int TH  = eic_pkg::THR_W;
  localparam int RC  = (RMW + 2) / 3;
  localparam int DC  = (DW + 3) / 4;
  localparam int RPW = 3 * RC;
  localparam int DPW = 4 * DC;
  localparam int SLW = 4 * RC + 2;
  localparam int SQW = 6 * RC;
  localparam int TLW = 2 * DC + TH + 1;
  localparam int TQW = 4 * DC + TH;
  localparam int CPW = (SQW > TQW) ? SQW : TQW;
  localparam int NS  = 4;

  logic [NS-1:0] v_q;
  logic [NS-1:0] en;
  logic [NS-1:0] last_q;

  always_comb begin
    en[NS-1] = !v_q[NS-1] || out_ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) last_q[0] <= last_i;
    for (int k = 1; k < NS; k++) begin
      if (en[k]) last_q[k] <= last_q[k-1];
    end
  end

  // Operands cut into equal chunks
  logic [RPW-1:0] rpad;
  logic [DPW-1:0] dpad;

  assign rpad = RPW'(rmag_i);
  assign dpad = DPW'(den_i);

  // Stage 7: chunk products of r^2 and threshold*d
  logic [2*RC-1:0] rr_q [6];
  logic [DC+TH-1:0] pd_q [4];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      rr_q[0] <= rpad[0 +: RC] * rpad[0 +: RC];
      rr_q[1] <= rpad[0 +: RC] * rpad[RC +: RC];
      rr_q[2] <= rpad[0 +: RC] * rpad[2*RC +: RC];
      rr_q[3] <= rpad[RC +: RC] * rpad[RC +: RC];
      rr_q[4] <= rpad[RC +: RC] * rpad[2*RC +: RC];
      rr_q[5] <= rpad[2*RC +: RC] * rpad[2*RC +: RC];
      for (int j = 0; j < 4; j++) begin
        pd_q[j] <= dpad[j*DC +: DC] * thr_i;
      end
    end
  end

  // Stage 8: low and high halves of each wide product
  logic [SLW-1:0] sl_q, sh_q;
  logic [TLW-1:0] tl_q, th_q;

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      sl_q <= SLW'(rr_q[0]) + (SLW'(rr_q[1]) << (RC + 1)) + (SLW'(rr_q[3]) << (2 * RC));
      sh_q <= (SLW'(rr_q[2]) << 1) + (SLW'(rr_q[4]) << (RC + 1)) + (SLW'(rr_q[5]) << (2 * RC));
      tl_q <= TLW'(pd_q[0]) + (TLW'(pd_q[1]) << DC);
      th_q <= TLW'(pd_q[2]) + (TLW'(pd_q[3]) << DC);
    end
  end

  // Stage 9: full r^2 and threshold*d
  logic [SQW-1:0] sq_q;
  logic [TQW-1:0] tq_q;

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      sq_q <= SQW'(sl_q) + (SQW'(sh_q) << (2 * RC));
      tq_q <= TQW'(tl_q) + (TQW'(th_q) << (2 * DC));
    end
  end

  // Stage 10: inlier when r^2 < threshold*d (zero denominator never passes)
  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      inl_o <= CPW'(sq_q) < CPW'(tq_q);
    end
  end

  assign out_valid_o = v_q[NS-1];
  assign last_o      = last_q[NS-1];

endmodule

// ===== hw/rtl/eic_count.sv =====
module eic_count #(
  parameter int COUNT_BITS = eic_pkg::COUNT_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  inl_i,
  input  logic                  last_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  is_inlier_o,
  output logic [COUNT_BITS-1:0] total_o,
  output logic                  done_o
);

  logic                  ov_q;
  logic                  en;
  logic                  take;
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic [COUNT_BITS-1:0] total_d;

  assign en         = !ov_q || out_ready_i;
  assign in_ready_o = en;
  assign take       = in_valid_i && en;

  // Saturating support count; clears after the last word of a set
  always_comb begin
    total_d = count_q;
    if (inl_i && (count_q != {COUNT_BITS{1'b1}})) begin
      total_d = count_q + 1'b1;
    end
    count_d = last_i ? '0 : total_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q    <= 1'b0;
      count_q <= '0;
    end else begin
      if (en) ov_q <= in_valid_i;
      if (take) count_q <= count_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (take) begin
      is_inlier_o <= inl_i;
      total_o     <= total_d;
      done_o      <= last_i;
    end
  end

  assign out_valid_o = ov_q;

endmodule
